>>> rtl/laa_pkg.sv
// Shared types and constants for the LIFO arena allocator.
package laa_pkg;

    // Default depth of the entry stack
    localparam int MAX_ENTRIES_DEF = 32;

    // Arena size register
    localparam int          ARENA_W      = 21;
    localparam logic [20:0] ARENA_RESET  = 21'd102400;
    localparam logic [20:0] ARENA_LIMIT  = 21'h100000;

    // Field widths
    localparam int SIZE_W  = 20;
    localparam int BYTES_W = 25;
    localparam int COUNT_W = 6;

    // Saturation points for reported counters
    localparam logic [24:0] BYTES_MAX = 25'h1FFFFFF;
    localparam logic [5:0]  COUNT_MAX = 6'h3F;

    // Request kinds
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_MISMATCH = 2'd3
    } laa_status_t;

    // Result word, offset in the lowest bits
    typedef struct packed {
        logic [COUNT_W-1:0] entry_count;
        logic [BYTES_W-1:0] peak_bytes;
        logic [BYTES_W-1:0] bytes_in_use;
        laa_status_t        status;
        logic               spilled;
        logic [SIZE_W-1:0]  offset;
    } laa_result_t;

endpackage

>>> rtl/laa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module laa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/laa_step.sv
// Next-state and result logic for one allocate or free.
module laa_step
    import laa_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    localparam int CW = $clog2(MAX_ENTRIES + 1),
    localparam int BW = SIZE_W + CW
) (
    input  logic [ARENA_W-1:0] arena_bytes,
    input  logic               action,
    input  logic [SIZE_W-1:0]  request_bytes,
    input  logic [SIZE_W-1:0]  freed_offset,
    input  logic [SIZE_W-1:0]  ent_size,
    input  logic               ent_spilled,
    input  logic [ARENA_W-1:0] arena_top,
    input  logic [BW-1:0]      live_bytes,
    input  logic [BW-1:0]      peak_bytes,
    input  logic [CW-1:0]      live_entries,
    output logic [ARENA_W-1:0] arena_top_next,
    output logic [BW-1:0]      live_bytes_next,
    output logic [BW-1:0]      peak_bytes_next,
    output logic [CW-1:0]      live_entries_next,
    output logic               push,
    output laa_result_t        result
);

    localparam int RBW = (BW > BYTES_W) ? BW : BYTES_W;
    localparam int RCW = (CW > COUNT_W) ? CW : COUNT_W;

    logic [ARENA_W-1:0] limit;
    logic [ARENA_W:0]   top_sum;
    logic               fits;
    logic [ARENA_W-1:0] back;
    logic               full;
    logic               empty;
    logic [BW-1:0]      live_sum;
    logic [RBW-1:0]     live_wide;
    logic [RBW-1:0]     peak_wide;
    logic [RCW-1:0]     cnt_wide;

    // arena fit test and pop-back offset
    always_comb
    begin
        limit    = (arena_bytes > ARENA_LIMIT) ? ARENA_LIMIT : arena_bytes;
        top_sum  = {1'b0, arena_top} + {2'b00, request_bytes};
        fits     = (top_sum <= {1'b0, limit}) && !arena_top[ARENA_W-1];
        back     = (arena_top >= {1'b0, ent_size}) ? (arena_top - {1'b0, ent_size})
                                                   : '0;
        full     = (live_entries >= CW'(MAX_ENTRIES));
        empty    = (live_entries == '0);
        live_sum = live_bytes + BW'(request_bytes);
    end

    // state update and result fields
    always_comb
    begin
        arena_top_next    = arena_top;
        live_bytes_next   = live_bytes;
        peak_bytes_next   = peak_bytes;
        live_entries_next = live_entries;
        push              = 1'b0;
        result.offset     = '0;
        result.spilled    = 1'b0;
        result.status     = ST_OK;
        if (action == ACT_ALLOC)
        begin
            if (full)
            begin
                result.status = ST_FULL;
            end
            else
            begin
                push              = 1'b1;
                live_entries_next = live_entries + CW'(1);
                live_bytes_next   = live_sum;
                if (live_sum > peak_bytes)
                begin
                    peak_bytes_next = live_sum;
                end
                if (fits)
                begin
                    result.offset  = arena_top[SIZE_W-1:0];
                    arena_top_next = top_sum[ARENA_W-1:0];
                end
                else
                begin
                    result.spilled = 1'b1;
                end
            end
        end
        else
        begin
            if (empty)
            begin
                result.status = ST_EMPTY;
            end
            else if (ent_spilled)
            begin
                result.spilled    = 1'b1;
                live_bytes_next   = live_bytes - BW'(ent_size);
                live_entries_next = live_entries - CW'(1);
            end
            else if (back != {1'b0, freed_offset})
            begin
                result.status = ST_MISMATCH;
            end
            else
            begin
                result.offset     = back[SIZE_W-1:0];
                arena_top_next    = back;
                live_bytes_next   = live_bytes - BW'(ent_size);
                live_entries_next = live_entries - CW'(1);
            end
        end

        // reported counters saturate at their field maxima
        live_wide = RBW'(live_bytes_next);
        peak_wide = RBW'(peak_bytes_next);
        cnt_wide  = RCW'(live_entries_next);
        result.bytes_in_use = (live_wide > RBW'(BYTES_MAX)) ? BYTES_MAX
                                                            : live_wide[BYTES_W-1:0];
        result.peak_bytes   = (peak_wide > RBW'(BYTES_MAX)) ? BYTES_MAX
                                                            : peak_wide[BYTES_W-1:0];
        result.entry_count  = (cnt_wide > RCW'(COUNT_MAX)) ? COUNT_MAX
                                                           : cnt_wide[COUNT_W-1:0];
    end

endmodule

>>> rtl/lifo_arena_allocator_top.sv
// Top level of the LIFO arena allocator: control, counters, entry stack RAM.
//
//  Channel | Signals                          | Word layout (low bit first)
//  --------+----------------------------------+--------------------------------------
//  in      | s_tvalid s_tready s_tdata s_tuser| tdata: request_bytes, freed_offset
//          |                                  | tuser: action
//  out     | m_tvalid m_tready m_tdata        | tdata: offset, spilled, status,
//          |                                  |   bytes_in_use, peak_bytes, entry_count
//  config  | cfg_we cfg_wdata                 | arena_bytes
//
// An allocate, and a free on an empty stack, finish straight from the input word; a
// free of a live entry first passes through S_FREE, waiting on the entry stack RAM read.
// One word is in work at a time; the output register holds a finished result
// while the next word is accepted, provided it is being taken in that cycle.
// Reset clears the counters, the arena top and the arena size to 102400 bytes.
// The entry stack RAM is not cleared; only live entries are ever read.
module lifo_arena_allocator_top
    import laa_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [39:0]        s_tdata,   // request_bytes[19:0], freed_offset[39:20]
    input  logic [0:0]         s_tuser,   // action[0]
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [79:0]        m_tdata,   // offset, spilled, status, bytes_in_use,
                                          // peak_bytes, entry_count, zero pad
    input  logic               cfg_we,
    input  logic [ARENA_W-1:0] cfg_wdata  // arena_bytes
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int BW = SIZE_W + CW;
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    typedef enum logic {
        S_IDLE,
        S_FREE
    } state_t;

    state_t             state_reg;
    logic [ARENA_W-1:0] arena_bytes_reg;
    logic [ARENA_W-1:0] arena_top_reg;
    logic [BW-1:0]      live_bytes_reg;
    logic [BW-1:0]      peak_bytes_reg;
    logic [CW-1:0]      live_entries_reg;
    logic [SIZE_W-1:0]  freed_reg;
    logic               out_valid_reg;
    laa_result_t        out_reg;

    logic               in_fire;
    logic               go_mem;
    logic               finish;
    logic               step_action;
    logic [SIZE_W-1:0]  step_freed;
    logic [CW-1:0]      cnt_dec;
    logic [SIZE_W:0]    ram_rdata;
    logic [ARENA_W-1:0] arena_top_next;
    logic [BW-1:0]      live_bytes_next;
    logic [BW-1:0]      peak_bytes_next;
    logic [CW-1:0]      live_entries_next;
    logic               push;
    laa_result_t        result;

    // handshake and sequencing
    assign s_tready    = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign in_fire     = s_tvalid && s_tready;
    assign go_mem      = in_fire && (s_tuser[0] == ACT_FREE) && (live_entries_reg != '0);
    assign finish      = (in_fire && !go_mem) || (state_reg == S_FREE);
    assign step_action = (state_reg == S_FREE) ? ACT_FREE : s_tuser[0];
    assign step_freed  = (state_reg == S_FREE) ? freed_reg : s_tdata[39:20];
    assign cnt_dec     = live_entries_reg - CW'(1);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg};

    // entry stack: {spilled, size}
    laa_ram #(
        .WIDTH (SIZE_W + 1),
        .DEPTH (MAX_ENTRIES)
    ) u_stack (
        .clk   (clk),
        .we    (finish && push),
        .waddr (live_entries_reg[AW-1:0]),
        .wdata ({result.spilled, s_tdata[SIZE_W-1:0]}),
        .re    (go_mem),
        .raddr (cnt_dec[AW-1:0]),
        .rdata (ram_rdata)
    );

    laa_step #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_step (
        .arena_bytes       (arena_bytes_reg),
        .action            (step_action),
        .request_bytes     (s_tdata[SIZE_W-1:0]),
        .freed_offset      (step_freed),
        .ent_size          (ram_rdata[SIZE_W-1:0]),
        .ent_spilled       (ram_rdata[SIZE_W]),
        .arena_top         (arena_top_reg),
        .live_bytes        (live_bytes_reg),
        .peak_bytes        (peak_bytes_reg),
        .live_entries      (live_entries_reg),
        .arena_top_next    (arena_top_next),
        .live_bytes_next   (live_bytes_next),
        .peak_bytes_next   (peak_bytes_next),
        .live_entries_next (live_entries_next),
        .push              (push),
        .result            (result)
    );

    // state, counters and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            arena_bytes_reg  <= ARENA_RESET;
            arena_top_reg    <= '0;
            live_bytes_reg   <= '0;
            peak_bytes_reg   <= '0;
            live_entries_reg <= '0;
            freed_reg        <= '0;
            out_valid_reg    <= 1'b0;
            out_reg          <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                arena_bytes_reg <= cfg_wdata;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (go_mem)
                    begin
                        state_reg <= S_FREE;
                        freed_reg <= s_tdata[39:20];
                    end
                end
                S_FREE:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (finish)
            begin
                arena_top_reg    <= arena_top_next;
                live_bytes_reg   <= live_bytes_next;
                peak_bytes_reg   <= peak_bytes_next;
                live_entries_reg <= live_entries_next;
                out_reg          <= result;
                out_valid_reg    <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output slot is always free while a free waits on the RAM
    a_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FREE) |-> !out_valid_reg)
        else $error("output register busy during free read");

    // entry count stays within the stack depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        live_entries_reg <= CW'(MAX_ENTRIES))
        else $error("entry count beyond stack depth");

    // arena top never passes the arena limit
    a_top_range: assert property (@(posedge clk) disable iff (!rst_n)
        arena_top_reg <= ARENA_LIMIT)
        else $error("arena top beyond limit");

    // peak never falls below bytes in use
    a_peak: assert property (@(posedge clk) disable iff (!rst_n)
        peak_bytes_reg >= live_bytes_reg)
        else $error("peak below bytes in use");

    // an allocate with room pushes exactly one entry
    a_push: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (s_tuser[0] == ACT_ALLOC) && (live_entries_reg < CW'(MAX_ENTRIES)))
        |=> (live_entries_reg == $past(live_entries_reg) + CW'(1)))
        else $error("allocate did not push");

endmodule
